// ----- hw/rtl/hdr_pq_pixel_encoder_assert.svh -----
// Assertion helpers for the PQ pixel encoder checkers.
// Each macro expects clk and arst_n in the enclosing scope.
`ifndef HDR_PQ_PIXEL_ENCODER_ASSERT_SVH
`define HDR_PQ_PIXEL_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define HPQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HPQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/hpq_pkg.sv -----
`default_nettype none
package hpq_pkg;

	typedef longint unsigned u64_t;
	typedef u64_t roots_t [31];

	localparam int PQ_ENTRIES_DEF = 1024;
	localparam int CODE_BITS_DEF  = 10;

	localparam int IN_CH_W   = 24;
	localparam int IN_DATA_W = 3 * IN_CH_W;
	localparam int SCALE_W   = 24;
	localparam int PEAK_W    = 14;
	localparam int CFG_IDX_W = 1;
	localparam int COEF_W    = 20;
	localparam int XPROD_W   = IN_CH_W - 1 + SCALE_W;
	localparam int NITS_W    = PEAK_W + 20;
	localparam int PROD_W    = COEF_W + NITS_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int V_W       = 34;
	localparam int EXP_W     = 6;
	localparam int REM_W     = V_W - 1;

	localparam logic [CFG_IDX_W-1:0] REG_EXPOSURE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK     = 1'b1;

	localparam logic [SCALE_W-1:0] EXPOSURE_RST = 24'd204800;
	localparam logic [PEAK_W-1:0]  PEAK_RST     = 14'd1000;

	localparam logic [V_W-1:0] NIT_CAP = 34'd10485760000;
	localparam logic [V_W-1:0] NIT_MIN = 34'd4;

	localparam u64_t Q30 = 64'd1 << 30;

	// BT.2087 Rec.709 to Rec.2020, Q0.20, row major
	localparam logic [COEF_W-1:0] MTX [9] = '{
		20'd657881, 20'd345277, 20'd45418,
		20'd72454,  20'd964208, 20'd11914,
		20'd17188,  20'd92289,  20'd939100
	};

	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

	function automatic u64_t isqrt64(u64_t x);
		u64_t r;
		u64_t b;
		u64_t xx;
		r  = 64'd0;
		b  = 64'd1 << 62;
		xx = x;
		while (b > xx) b = b >> 2;
		while (b != 64'd0) begin
			if (xx >= r + b) begin
				xx = xx - (r + b);
				r  = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// shift and subtract long division, used only while building tables
	function automatic u64_t udiv64(u64_t num, u64_t den);
		u64_t q;
		u64_t rr;
		q  = 64'd0;
		rr = 64'd0;
		for (int i = 63; i >= 0; i--) begin
			rr = {rr[62:0], num[i]};
			if (rr >= den) begin
				rr   = rr - den;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic u64_t top_bit(u64_t x);
		u64_t e;
		u64_t xx;
		e  = 64'd0;
		xx = x;
		while (xx > 64'd1) begin
			xx = xx >> 1;
			e  = e + 64'd1;
		end
		return e;
	endfunction

	function automatic u64_t log2_q30(u64_t x);
		u64_t e;
		u64_t m;
		u64_t res;
		e   = top_bit(x);
		m   = (e >= 64'd30) ? (x >> (e - 64'd30)) : (x << (64'd30 - e));
		res = e << 30;
		for (int i = 1; i <= 30; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m   = m >> 1;
				res = res | (64'd1 << (30 - i));
			end
		end
		return res;
	endfunction

	function automatic roots_t make_roots();
		roots_t rt;
		rt[0] = 64'd2 << 30;
		for (int i = 1; i <= 30; i++) rt[i] = isqrt64(rt[i-1] << 30);
		return rt;
	endfunction

	function automatic u64_t pow2neg(u64_t t, roots_t rt);
		u64_t n;
		u64_t f;
		u64_t g;
		u64_t acc;
		n = t >> 30;
		f = t & (Q30 - 64'd1);
		if (f == 64'd0) return (n > 64'd30) ? 64'd0 : (Q30 >> n);
		g   = Q30 - f;
		acc = Q30;
		for (int i = 1; i <= 30; i++)
			if (((g >> (30 - i)) & 64'd1) != 64'd0) acc = (acc * rt[i]) >> 30;
		if (n + 64'd1 >= 64'd63) return 64'd0;
		return acc >> (n + 64'd1);
	endfunction

	function automatic u64_t pq_of_nits(u64_t v_in, roots_t rt, u64_t log_cap);
		u64_t v;
		u64_t ym;
		u64_t lv;
		u64_t a;
		u64_t num;
		u64_t den;
		u64_t r;
		u64_t lr;
		v  = v_in;
		ym = 64'd0;
		if (v > u64_t'(NIT_CAP)) v = u64_t'(NIT_CAP);
		if (v != 64'd0) begin
			lv = log2_q30(v);
			a  = (log_cap > lv) ? (log_cap - lv) : 64'd0;
			ym = pow2neg((a * 64'd2610) >> 14, rt);
		end
		num = (64'd107 << 30) + 64'd2413 * ym;
		den = (64'd128 << 30) + 64'd2392 * ym;
		r   = udiv64((num >> 10) << 30, den >> 10);
		if (r >= Q30) return Q30;
		lr = log2_q30(r);
		a  = (64'd30 << 30) - lr;
		return pow2neg((a * 64'd2523) >> 5, rt);
	endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/hpq_scale_mtx.sv -----
`default_nettype none
module hpq_scale_mtx (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   adv,
	input  hpq_pkg::ctl_t                          ctl_in,
	input  logic signed [hpq_pkg::IN_CH_W-1:0]     ch_in [3],
	input  logic        [hpq_pkg::SCALE_W-1:0]     scale,
	input  logic        [hpq_pkg::PEAK_W-1:0]      peak,
	output hpq_pkg::ctl_t                          ctl_s4,
	output logic        [hpq_pkg::V_W-1:0]         v_s4 [3]
);
	import hpq_pkg::*;

	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic [XPROD_W-1:0] xp_s1 [3];
	logic [NITS_W-1:0]  nits_s2 [3];
	logic [PROD_W-1:0]  mp_s3 [9];
	logic [XPROD_W-1:0] peak_ext;
	logic [SUM_W-1:0]   sum [3];
	logic [SUM_W-21:0]  vr [3];

	assign peak_ext = XPROD_W'({peak, 20'd0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = SUM_W'(mp_s3[c*3]) + SUM_W'(mp_s3[c*3+1]) + SUM_W'(mp_s3[c*3+2])
				+ SUM_W'(20'h80000);
			vr[c] = sum[c][SUM_W-1:20];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 3; c++) begin
				// negative light counts as zero
				xp_s1[c] <= ch_in[c][IN_CH_W-1] ? '0
					: XPROD_W'(ch_in[c][IN_CH_W-2:0]) * XPROD_W'(scale);
				nits_s2[c] <= (xp_s1[c] > peak_ext) ? NITS_W'(peak_ext)
					: xp_s1[c][NITS_W-1:0];
				if (vr[c] > (SUM_W-20)'(NIT_CAP))
					v_s4[c] <= NIT_CAP;
				else if (vr[c] < (SUM_W-20)'(NIT_MIN))
					v_s4[c] <= NIT_MIN;
				else
					v_s4[c] <= vr[c][V_W-1:0];
			end
			for (int r = 0; r < 3; r++)
				for (int k = 0; k < 3; k++)
					mp_s3[r*3+k] <= PROD_W'(MTX[r*3+k]) * PROD_W'(nits_s2[k]);
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/hpq_pq_encode.sv -----
`default_nettype none
module hpq_pq_encode #(
	parameter int PQ_TABLE_ENTRIES = hpq_pkg::PQ_ENTRIES_DEF,
	parameter int CODE_BITS        = hpq_pkg::CODE_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      adv,
	input  logic [hpq_pkg::V_W-1:0]   v_in,
	output logic [CODE_BITS-1:0]      code_s9
);
	import hpq_pkg::*;

	localparam int PER_OCT  = PQ_TABLE_ENTRIES / 32;
	localparam int ROM_N    = 32 * PER_OCT + 1;
	localparam int ADDR_W   = $clog2(ROM_N);
	localparam int P_W      = $clog2(PER_OCT + 1);
	localparam int POS_W    = REM_W + P_W;
	localparam int NODE_W   = CODE_BITS + 16;
	localparam int MPROD_W  = NODE_W + REM_W;
	localparam int MAX_CODE = (1 << CODE_BITS) - 1;

	typedef logic [NODE_W-1:0] rom_t [ROM_N];

	function automatic rom_t build_rom();
		rom_t   t;
		roots_t rt;
		u64_t   lc;
		u64_t   v;
		rt = make_roots();
		lc = log2_q30(u64_t'(NIT_CAP));
		for (int s = 0; s < 32; s++) begin
			for (int k = 0; k < PER_OCT; k++) begin
				v = udiv64((u64_t'(PER_OCT) + u64_t'(k)) << (s + 2), u64_t'(PER_OCT));
				t[s*PER_OCT+k] = NODE_W'((pq_of_nits(v, rt, lc) * u64_t'(MAX_CODE)) >> 14);
			end
		end
		t[ROM_N-1] = NODE_W'((pq_of_nits(64'd1 << 34, rt, lc) * u64_t'(MAX_CODE)) >> 14);
		return t;
	endfunction

	localparam rom_t PQ_ROM = build_rom();

	logic [EXP_W-1:0]   e;
	logic [EXP_W-1:0]   e_s5, e_s6, e_s7, e_s8;
	logic [REM_W-1:0]   rem_s5;
	logic [POS_W-1:0]   pos;
	logic [POS_W-1:0]   wmask;
	logic [ADDR_W-1:0]  j_s6;
	logic [ADDR_W-1:0]  j1;
	logic [REM_W-1:0]   w_s6, w_s7;
	logic [NODE_W-1:0]  n0_s7, n1_s7, n0_s8;
	logic               up_s8;
	logic [MPROD_W-1:0] mp_s8;
	logic [NODE_W-1:0]  diff;
	logic [NODE_W-1:0]  delta;
	logic [NODE_W:0]    val;
	logic [NODE_W:0]    rnd;
	logic [CODE_BITS:0] code_r;

	// leading one of the nits value picks the octave
	always_comb begin
		e = '0;
		for (int i = 0; i < V_W; i++)
			if (v_in[i]) e = EXP_W'(i);
	end

	assign pos   = POS_W'(rem_s5) * POS_W'(PER_OCT);
	assign wmask = (POS_W'(1) << e_s5) - POS_W'(1);
	assign j1    = j_s6 + ADDR_W'(1);
	assign diff  = (n1_s7 >= n0_s7) ? (n1_s7 - n0_s7) : (n0_s7 - n1_s7);
	assign delta = NODE_W'(mp_s8 >> e_s8);
	assign val   = up_s8 ? ((NODE_W+1)'(n0_s8) + (NODE_W+1)'(delta))
		: ((NODE_W+1)'(n0_s8) - (NODE_W+1)'(delta));
	assign rnd    = val + (NODE_W+1)'(17'h08000);
	assign code_r = rnd[NODE_W:16];

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s5   <= e;
			rem_s5 <= REM_W'(v_in & ~(V_W'(1) << e));

			e_s6 <= e_s5;
			j_s6 <= ADDR_W'(32'(e_s5 - EXP_W'(2)) * PER_OCT) + ADDR_W'(pos >> e_s5);
			w_s6 <= REM_W'(pos & wmask);

			e_s7  <= e_s6;
			w_s7  <= w_s6;
			n0_s7 <= PQ_ROM[j_s6];
			n1_s7 <= PQ_ROM[j1];

			e_s8  <= e_s7;
			n0_s8 <= n0_s7;
			up_s8 <= (n1_s7 >= n0_s7);
			mp_s8 <= MPROD_W'(diff) * MPROD_W'(w_s7);

			code_s9 <= (code_r > (CODE_BITS+1)'(MAX_CODE)) ? CODE_BITS'(MAX_CODE)
				: code_r[CODE_BITS-1:0];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/hdr_pq_pixel_encoder.sv -----
`default_nettype none
// Channel   Signals                          Carries
// s_*       tvalid tready tdata[71:0] tlast  one linear Rec.709 pixel, tlast = frame end
// m_*       tvalid tready tdata tlast        one 10-bit PQ Rec.2020 pixel, tlast = frame end
// cfg_*     we index data[23:0]              register writes (0 exposure, 1 peak nits)
//
// One pixel per clock sustained while the output is not stalled.
// The nine stages are scale, peak limit, matrix multiply, matrix sum, octave find,
// table address, table read, interpolation multiply and final rounding.
// arst_n clears all valid bits and restores the register defaults.
// A stall on the output freezes every stage at once, so items are held in place.
module hdr_pq_pixel_encoder #(
	parameter int PQ_TABLE_ENTRIES = hpq_pkg::PQ_ENTRIES_DEF,
	parameter int CODE_BITS        = hpq_pkg::CODE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [hpq_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [hpq_pkg::SCALE_W-1:0]           cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// red_linear [23:0], green_linear [47:24], blue_linear [71:48]
	input  logic [hpq_pkg::IN_DATA_W-1:0]         s_tdata,
	input  logic                                  s_tlast,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// red_code, green_code, blue_code, CODE_BITS each from bit 0 up, zero pad
	output logic [(((3*CODE_BITS+7)>>3)<<3)-1:0]  m_tdata,
	output logic                                  m_tlast
);
	import hpq_pkg::*;

	localparam int OUT_DATA_W = ((3 * CODE_BITS + 7) / 8) * 8;

	logic [SCALE_W-1:0] exposure_q;
	logic [PEAK_W-1:0]  peak_q;

	logic adv;
	ctl_t ctl_in, ctl_s4, ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;
	logic signed [IN_CH_W-1:0] ch_in [3];
	logic [V_W-1:0]       v_s4 [3];
	logic [CODE_BITS-1:0] code_s9 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exposure_q <= EXPOSURE_RST;
			peak_q     <= PEAK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXPOSURE: exposure_q <= cfg_data;
				REG_PEAK:     peak_q     <= cfg_data[PEAK_W-1:0];
				default:      ;
			endcase
		end
	end

	// advance everything whenever the output slot is free or being drained
	assign adv      = !ctl_s9.valid || m_tready;
	assign s_tready = adv;
	assign ctl_in   = '{valid: s_tvalid, last: s_tlast};

	assign ch_in[0] = s_tdata[IN_CH_W-1:0];
	assign ch_in[1] = s_tdata[2*IN_CH_W-1:IN_CH_W];
	assign ch_in[2] = s_tdata[3*IN_CH_W-1:2*IN_CH_W];

	hpq_scale_mtx u_scale_mtx (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ctl_in (ctl_in),
		.ch_in  (ch_in),
		.scale  (exposure_q),
		.peak   (peak_q),
		.ctl_s4 (ctl_s4),
		.v_s4   (v_s4)
	);

	for (genvar c = 0; c < 3; c++) begin : g_enc
		hpq_pq_encode #(
			.PQ_TABLE_ENTRIES (PQ_TABLE_ENTRIES),
			.CODE_BITS        (CODE_BITS)
		) u_enc (
			.clk     (clk),
			.adv     (adv),
			.v_in    (v_s4[c]),
			.code_s9 (code_s9[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else if (adv) begin
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	assign m_tvalid = ctl_s9.valid;
	assign m_tlast  = ctl_s9.last;
	assign m_tdata  = OUT_DATA_W'({code_s9[2], code_s9[1], code_s9[0]});
endmodule
`default_nettype wire

// ----- hw/rtl/hpq_checker.sv -----
`default_nettype none
`include "hdr_pq_pixel_encoder_assert.svh"
module hpq_checker #(
	parameter int OUT_DATA_W = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic                  m_tlast
);
	localparam int DEPTH = 9;

	logic [3:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			inflight_q <= '0;
		else
			inflight_q <= inflight_q + 4'(s_tvalid && s_tready) - 4'(m_tvalid && m_tready);
	end

	`HPQ_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")
	`HPQ_ASSERT_IMP(a_ready_link, 1'b1, s_tready == (!m_tvalid || m_tready),
		"input ready does not follow output slot")
	`HPQ_ASSERT_IMP(a_no_phantom, m_tvalid, inflight_q != 4'd0,
		"output item without accepted input")
	`HPQ_ASSERT_IMP(a_depth, 1'b1, inflight_q <= 4'(DEPTH),
		"more items in flight than pipeline stages")
endmodule

bind hdr_pq_pixel_encoder hpq_checker #(.OUT_DATA_W(OUT_DATA_W)) u_hpq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import hpq_pkg::*;

	typedef longint unsigned u64;

	typedef struct packed {
		logic [23:0] red;
		logic [23:0] green;
		logic [23:0] blue;
		logic        last;
	} pixel_t;

	typedef struct packed {
		logic [9:0] red;
		logic [9:0] green;
		logic [9:0] blue;
		logic       last;
	} code_t;

	localparam int SEG_NODES = 32;
	localparam int NODE_CNT  = 32 * SEG_NODES + 1;
	localparam u64 ONE_Q30   = 64'd1 << 30;
	localparam u64 TOP_NITS  = 64'd10000 << 20;
	localparam u64 CODE_MAX  = 64'd1023;
	localparam int WD_LIMIT  = 4000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCALE_W-1:0]   cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [71:0]          s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [31:0]          m_tdata;
	logic                 m_tlast;

	hdr_pq_pixel_encoder uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	pixel_t pixels_pending[$];
	pixel_t pixel_cur;
	code_t  codes_expected[$];
	int     errors;
	int     pixels_sent;
	int     codes_seen;
	int     frames_seen;
	int     idle_pct;
	int     quiet_cycles;
	u64     exposure_q;
	u64     peak_q;
	u64     pq_node [NODE_CNT];
	u64     half_roots [31];
	u64     cap_log;

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	// ---- PQ encoder predictor ----
	function automatic u64 sqrt_floor(u64 x);
		u64 r, b, rest;
		r = 0;
		b = 64'd1 << 62;
		rest = x;
		while (b > rest) b = b >> 2;
		while (b != 0) begin
			if (rest >= r + b) begin
				rest = rest - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic u64 msb_pos(u64 x);
		u64 n, t;
		n = 0;
		t = x;
		while (t > 1) begin
			t = t >> 1;
			n++;
		end
		return n;
	endfunction

	function automatic u64 log2_fix(u64 x);
		u64 e, m, acc;
		e = msb_pos(x);
		m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
		acc = e << 30;
		for (int i = 1; i <= 30; i++) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				acc = acc | (64'd1 << (30 - i));
			end
		end
		return acc;
	endfunction

	// 2^-t, both in Q30
	function automatic u64 exp2_neg(u64 t);
		u64 whole, frac, g, acc;
		whole = t >> 30;
		frac = t & (ONE_Q30 - 1);
		if (frac == 0) return (whole > 30) ? 64'd0 : (ONE_Q30 >> whole);
		g = ONE_Q30 - frac;
		acc = ONE_Q30;
		for (int i = 1; i <= 30; i++)
			if (g[30 - i]) acc = (acc * half_roots[i]) >> 30;
		if (whole + 1 >= 63) return 64'd0;
		return acc >> (whole + 1);
	endfunction

	function automatic u64 pq_curve(u64 nits_in);
		u64 v, ym, d, num, den, ratio;
		v = (nits_in > TOP_NITS) ? TOP_NITS : nits_in;
		ym = 0;
		if (v != 0) begin
			d = log2_fix(v);
			d = (cap_log > d) ? cap_log - d : 64'd0;
			ym = exp2_neg((d * 2610) >> 14);
		end
		num = (64'd107 << 30) + 2413 * ym;
		den = (64'd128 << 30) + 2392 * ym;
		ratio = ((num >> 10) << 30) / (den >> 10);
		if (ratio >= ONE_Q30) return ONE_Q30;
		d = (64'd30 << 30) - log2_fix(ratio);
		return exp2_neg((d * 2523) >> 5);
	endfunction

	function automatic void build_pq_nodes();
		u64 seg, k, v;
		half_roots[0] = 64'd2 << 30;
		for (int i = 1; i <= 30; i++) half_roots[i] = sqrt_floor(half_roots[i-1] << 30);
		cap_log = log2_fix(TOP_NITS);
		for (int j = 0; j < NODE_CNT; j++) begin
			seg = j / SEG_NODES;
			k = j % SEG_NODES;
			v = ((SEG_NODES + k) << (seg + 2)) / SEG_NODES;
			pq_node[j] = ((pq_curve(v) * CODE_MAX) >> 14) & 64'hFFFF_FFFF;
		end
	endfunction

	function automatic logic [9:0] nits_to_code(u64 nits_in);
		u64 v, e, pos, k, w, j, n0, n1, val, code;
		v = (nits_in > TOP_NITS) ? TOP_NITS : nits_in;
		if (v < 4) v = 4;
		e = msb_pos(v);
		pos = (v - (64'd1 << e)) * SEG_NODES;
		k = pos >> e;
		w = pos & ((64'd1 << e) - 1);
		j = (e - 2) * SEG_NODES + k;
		n0 = pq_node[j];
		n1 = pq_node[j + 1];
		val = (n1 >= n0) ? n0 + (((n1 - n0) * w) >> e) : n0 - (((n0 - n1) * w) >> e);
		code = (val + 64'h8000) >> 16;
		return (code > CODE_MAX) ? CODE_MAX[9:0] : code[9:0];
	endfunction

	function automatic code_t encode_pixel(pixel_t p);
		u64 lin [3];
		u64 nits [3];
		u64 sum;
		code_t c;
		logic [9:0] res [3];
		lin[0] = p.red;
		lin[1] = p.green;
		lin[2] = p.blue;
		for (int i = 0; i < 3; i++) begin
			if (lin[i][23]) lin[i] = 0;
			nits[i] = lin[i] * exposure_q;
			if (nits[i] > (peak_q << 20)) nits[i] = peak_q << 20;
		end
		for (int i = 0; i < 3; i++) begin
			sum = u64'(MTX[3*i]) * nits[0] + u64'(MTX[3*i+1]) * nits[1]
				+ u64'(MTX[3*i+2]) * nits[2];
			res[i] = nits_to_code((sum + (64'd1 << 19)) >> 20);
		end
		c.red = res[0];
		c.green = res[1];
		c.blue = res[2];
		c.last = p.last;
		return c;
	endfunction

	// ---- driver ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				codes_expected.insert(codes_expected.size(), encode_pixel(pixel_cur));
				pixels_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pixels_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					pixel_cur = pixels_pending.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {pixel_cur.blue, pixel_cur.green, pixel_cur.red};
					s_tlast <= pixel_cur.last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---- monitor ----
	task automatic report(string what, int got, int want);
		$display("mismatch %s at code %0d: got %0d, expected %0d", what, codes_seen, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		code_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= idle_pct);
			if (m_tvalid && m_tready) begin
				if (codes_expected.size() == 0) begin
					report("unexpected item", int'(m_tdata), 0);
				end else begin
					want = codes_expected.pop_front();
					if (m_tdata[9:0] != want.red) report("red", m_tdata[9:0], want.red);
					if (m_tdata[19:10] != want.green)
						report("green", m_tdata[19:10], want.green);
					if (m_tdata[29:20] != want.blue)
						report("blue", m_tdata[29:20], want.blue);
					if (m_tlast != want.last) report("last", m_tlast, want.last);
				end
				codes_seen++;
				if (m_tlast) frames_seen++;
			end
			if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WD_LIMIT) begin
				$display("[hdr_pq_pixel_encoder] ERROR");
				$finish;
			end
		end
	end

	// ---- stimulus ----
	function automatic logic [23:0] rand_channel();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 45) return 24'($urandom_range(0, 8191));
		if (sel < 65) return 24'($urandom_range(0, 63));
		if (sel < 80) return 24'($urandom_range(0, 131071));
		return 24'($urandom);
	endfunction

	task automatic add_pixel(logic [23:0] r, logic [23:0] g, logic [23:0] b, logic last);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.last = last;
		pixels_pending.insert(pixels_pending.size(), p);
	endtask

	task automatic add_random(int n);
		for (int i = 0; i < n; i++)
			add_pixel(rand_channel(), rand_channel(), rand_channel(),
				$urandom_range(0, 15) == 0);
	endtask

	task automatic drain();
		while (pixels_pending.size() != 0 || s_tvalid || codes_expected.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_EXPOSURE) exposure_q = val;
		else peak_q = val[13:0];
	endtask

	task automatic set_config(logic [23:0] scale, logic [13:0] peak);
		write_reg(REG_EXPOSURE, scale);
		write_reg(REG_PEAK, {10'd0, peak});
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		errors = 0;
		pixels_sent = 0;
		codes_seen = 0;
		frames_seen = 0;
		idle_pct = 23;
		exposure_q = 204800;
		peak_q = 1000;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		build_pq_nodes();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zeros, extremes, negatives, tiny and near-peak values
		add_pixel(24'h000000, 24'h000000, 24'h000000, 1'b0);
		add_pixel(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
		add_pixel(24'h800000, 24'h800000, 24'h800000, 1'b0);
		add_pixel(24'hFFFFFF, 24'h000001, 24'h7FFFFF, 1'b0);
		add_pixel(24'h000001, 24'h000002, 24'h000003, 1'b1);
		add_pixel(24'h001000, 24'h000000, 24'h000000, 1'b0);
		add_pixel(24'h000000, 24'h001000, 24'h000000, 1'b0);
		add_pixel(24'h000000, 24'h000000, 24'h001000, 1'b0);
		add_pixel(24'h001400, 24'h0013FF, 24'h001401, 1'b0);
		add_pixel(24'h7FFFFF, 24'h800000, 24'h000000, 1'b1);
		add_pixel(24'hAAAAAA, 24'h555555, 24'h2AAAAA, 1'b0);
		add_pixel(24'h000080, 24'h000200, 24'h000800, 1'b1);
		drain();

		// peak above 10000 with full exposure: top code
		set_config(24'hFFFFFF, 14'h3FFF);
		add_pixel(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b0);
		add_pixel(24'h000001, 24'h000000, 24'h000000, 1'b0);
		add_pixel(24'h800000, 24'h7FFFFF, 24'h800000, 1'b1);
		add_random(120);
		drain();

		// zero exposure, with zero peak and then peak 10000: everything at the floor
		set_config(24'd0, 14'd0);
		add_pixel(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1'b1);
		add_random(60);
		drain();
		set_config(24'd0, 14'd10000);
		add_random(40);
		drain();

		// unity exposure, peak at 10000 nits, no idling on either side
		set_config(24'd256, 14'd10000);
		idle_pct = 0;
		add_random(200);
		drain();
		idle_pct = 23;

		// sender holds off mid-phase until the pipe is empty
		set_config(24'd204800, 14'd1000);
		add_random(100);
		drain();
		add_random(100);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			set_config(24'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16)),
				14'($urandom_range(0, 16383)));
			add_random(100);
			drain();
		end

		$display("sent %0d pixels, checked %0d codes over %0d frames", pixels_sent,
			codes_seen, frames_seen);
		$display("exposure and peak covered zero, defaults, unity, maximum and random");
		if (errors == 0) begin
			$display("[hdr_pq_pixel_encoder] OK");
		end else begin
			$display("[hdr_pq_pixel_encoder] ERROR");
		end
		$finish;
	end

endmodule
